// ===== sv/bcv_pkg.sv =====
`timescale 1ns / 1ps

package bcv_pkg;

	localparam int WINDOW_DEPTH_DEF = 10;

	localparam int MODE_W    = 1;
	localparam int SAMPLE_W  = 17;
	localparam int CHARGE_W  = 10;
	localparam int AVG_W     = 16;
	localparam int REG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int OFFSET_W  = 11;
	localparam int DVS_W     = 16;
	localparam int PROD_W    = 26;
	localparam int ITER_W    = $clog2(PROD_W + 1);
	localparam int STEP_W    = 3;
	localparam int SEL_W     = 4;

	localparam logic [MODE_W-1:0] MODE_SPEED = 1'b0;
	localparam logic [MODE_W-1:0] MODE_VOLT  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL,
		REG_UPPER,
		REG_LOWER,
		REG_EMPTY
	} cfg_reg_t;

	localparam logic [REG_W-1:0] FULL_RST  = 13'd4200;
	localparam logic [REG_W-1:0] UPPER_RST = 13'd3930;
	localparam logic [REG_W-1:0] LOWER_RST = 13'd3650;
	localparam logic [REG_W-1:0] EMPTY_RST = 13'd3600;

	localparam int SPEED_STEP_MM = 500;
	localparam int SPEED_STEPS   = 11;

	localparam logic [CHARGE_W-1:0] CHARGE_MAX  = 10'd1000;
	localparam logic [CHARGE_W-1:0] CHARGE_ZERO = 10'd0;
	localparam logic [CHARGE_W-1:0] TOP_BASE    = 10'd850;
	localparam logic [CHARGE_W-1:0] TOP_SCALE   = 10'd150;
	localparam logic [CHARGE_W-1:0] MID_BASE    = 10'd100;
	localparam logic [CHARGE_W-1:0] MID_SCALE   = 10'd750;
	localparam logic [CHARGE_W-1:0] LOW_BASE    = 10'd0;
	localparam logic [CHARGE_W-1:0] LOW_SCALE   = 10'd100;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_WINDOW,
		OP_AVG_LOAD,
		OP_DIV_STEP,
		OP_SEG_PICK,
		OP_SEG_LOAD,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_NOT_VOLT,
		COND_DIV_MORE,
		COND_FLAT,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
	localparam logic [STEP_W-1:0] STEP_WINDOW   = 3'd1;
	localparam logic [STEP_W-1:0] STEP_AVG_LOAD = 3'd2;
	localparam logic [STEP_W-1:0] STEP_AVG_DIV  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_SEG_PICK = 3'd4;
	localparam logic [STEP_W-1:0] STEP_SEG_LOAD = 3'd5;
	localparam logic [STEP_W-1:0] STEP_SEG_DIV  = 3'd6;
	localparam logic [STEP_W-1:0] STEP_EMIT     = 3'd7;
	localparam logic [STEP_W-1:0] STEP_LAST     = STEP_EMIT;

	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw = '{op: OP_WAIT, cond: COND_NOT_VOLT, target: STEP_IDLE};
		case (step)
			STEP_IDLE:     cw = '{op: OP_WAIT,     cond: COND_NOT_VOLT, target: STEP_IDLE};
			STEP_WINDOW:   cw = '{op: OP_WINDOW,   cond: COND_NONE,     target: STEP_IDLE};
			STEP_AVG_LOAD: cw = '{op: OP_AVG_LOAD, cond: COND_NONE,     target: STEP_IDLE};
			STEP_AVG_DIV:  cw = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: STEP_AVG_DIV};
			STEP_SEG_PICK: cw = '{op: OP_SEG_PICK, cond: COND_NONE,     target: STEP_IDLE};
			STEP_SEG_LOAD: cw = '{op: OP_SEG_LOAD, cond: COND_FLAT,     target: STEP_EMIT};
			STEP_SEG_DIV:  cw = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: STEP_SEG_DIV};
			STEP_EMIT:     cw = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: STEP_EMIT};
			default:       cw = '{op: OP_WAIT,     cond: COND_NOT_VOLT, target: STEP_IDLE};
		endcase
		return cw;
	endfunction

	function automatic logic [OFFSET_W-1:0] load_offset(input logic [SEL_W-1:0] sel);
		logic [OFFSET_W-1:0] mv;
		case (sel)
			4'd0:    mv = 11'd0;
			4'd1:    mv = 11'd100;
			4'd2:    mv = 11'd300;
			4'd3:    mv = 11'd400;
			4'd4:    mv = 11'd500;
			4'd5:    mv = 11'd600;
			4'd6:    mv = 11'd700;
			4'd7:    mv = 11'd800;
			4'd8:    mv = 11'd900;
			4'd9:    mv = 11'd1000;
			4'd10:   mv = 11'd1100;
			default: mv = 11'd1200;
		endcase
		return mv;
	endfunction

endpackage

// ===== sv/bcv_sample_if.sv =====
`timescale 1ns / 1ps

interface bcv_sample_if;
	import bcv_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic signed [SAMPLE_W-1:0] sample_value;

	modport source (output valid, output mode, output sample_value, input ready);
	modport sink (input valid, input mode, input sample_value, output ready);
endinterface

// ===== sv/bcv_result_if.sv =====
`timescale 1ns / 1ps

interface bcv_result_if;
	import bcv_pkg::*;

	logic                valid;
	logic                ready;
	logic [CHARGE_W-1:0] charge_tenths;
	logic [AVG_W-1:0]    avg_cell_eighth_mv;

	modport source (output valid, output charge_tenths, output avg_cell_eighth_mv, input ready);
	modport sink (input valid, input charge_tenths, input avg_cell_eighth_mv, output ready);
endinterface

// ===== sv/battery_charge_from_voltage.sv =====
`timescale 1ns / 1ps
// Speed item: no result; the sequencer stays idle, next item taken in the following cycle.
// Voltage item: result at emit, held off while an earlier result is not taken; the segment
// divide is skipped when the segment is flat or the average is at or below empty; the next
// item is taken in idle. The shared restoring divider gives one quotient bit per cycle:
// 16 + clog2(WINDOW_DEPTH + 1) bits for the window average (20 at the default depth of 10),
// 26 bits for the segment map, plus five sequencer steps around them.
// Reset clears the sequencer, window count, sum, load offset and registers to defaults.
module battery_charge_from_voltage #(
	parameter int WINDOW_DEPTH = bcv_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bcv_sample_if.sink                      sample,
	bcv_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [bcv_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bcv_pkg::REG_W-1:0]       cfg_data
);
	import bcv_pkg::*;

	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = AVG_W + CNT_W;
	localparam int ALIGN  = PROD_W - SUM_W;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
	localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(WINDOW_DEPTH);
	localparam logic [ITER_W-1:0] AVG_ITERS = ITER_W'(SUM_W);
	localparam logic [ITER_W-1:0] SEG_ITERS = ITER_W'(PROD_W);

	logic [REG_W-1:0] full_q, upper_q, lower_q, empty_q;

	logic [STEP_W-1:0]   step_q;
	logic [STEP_W-1:0]   step_next;
	ctrl_word_t          cw;
	logic                jump;

	logic [OFFSET_W-1:0] offset_q;
	logic [AVG_W-1:0]    win_q [WINDOW_DEPTH];
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    fill_q;
	logic [SUM_W-1:0]    sum_q;
	logic [AVG_W-1:0]    entry_q;

	logic [PROD_W-1:0]   dvd_q;
	logic [DVS_W-1:0]    rem_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [ITER_W-1:0]   iter_q;
	logic [DVS_W:0]      trial_in;
	logic [DVS_W:0]      trial;
	logic                trial_ge;

	logic [AVG_W-1:0]    avg_q;
	logic [AVG_W-1:0]    num_q;
	logic [DVS_W-1:0]    den_q;
	logic [CHARGE_W-1:0] base_q;
	logic [CHARGE_W-1:0] scale_q;
	logic                flat_q;
	logic [CHARGE_W-1:0] flat_val_q;

	logic                out_valid_q;
	logic [CHARGE_W-1:0] out_charge_q;
	logic [AVG_W-1:0]    out_avg_q;

	logic                take;
	logic                take_volt;
	logic                take_speed;
	logic                out_busy;

	logic [SAMPLE_W-1:0] mag;
	logic [SEL_W-1:0]    speed_sel;
	logic [SAMPLE_W+1:0] entry_sum;
	logic [AVG_W-1:0]    entry_clamped;

	logic [AVG_W-1:0]    v;
	logic [AVG_W-1:0]    th_full, th_upper, th_lower, th_empty;
	logic [AVG_W-1:0]    pick_num;
	logic [DVS_W-1:0]    pick_den;
	logic [CHARGE_W-1:0] pick_base, pick_scale, pick_flat_val;
	logic                pick_flat;

	logic [PROD_W:0]     charge_sum;
	logic [CHARGE_W-1:0] charge;
	logic                win_full;

	assign cw         = ucode(step_q);
	assign take       = sample.valid && sample.ready;
	assign take_volt  = take && (sample.mode == MODE_VOLT);
	assign take_speed = take && (sample.mode == MODE_SPEED);
	assign out_busy   = out_valid_q && !result.ready;
	assign win_full   = (fill_q == CNT_FULL);

	assign sample.ready              = (cw.op == OP_WAIT);
	assign result.valid              = out_valid_q;
	assign result.charge_tenths      = out_charge_q;
	assign result.avg_cell_eighth_mv = out_avg_q;

	always_comb begin
		case (cw.cond)
			COND_NONE:     jump = 1'b0;
			COND_NOT_VOLT: jump = !take_volt;
			COND_DIV_MORE: jump = (iter_q != ITER_W'(1));
			COND_FLAT:     jump = flat_q;
			COND_OUT_BUSY: jump = out_busy;
			default:       jump = 1'b0;
		endcase
		if (jump) begin
			step_next = cw.target;
		end else if (step_q == STEP_LAST) begin
			step_next = STEP_IDLE;
		end else begin
			step_next = step_q + STEP_W'(1);
		end
	end

	always_comb begin
		mag = sample.sample_value[SAMPLE_W-1] ?
			(~sample.sample_value + SAMPLE_W'(1)) : sample.sample_value;
		speed_sel = '0;
		for (int k = 1; k <= SPEED_STEPS; k++) begin
			if (mag > SAMPLE_W'(k * SPEED_STEP_MM)) begin
				speed_sel = SEL_W'(k);
			end
		end
		entry_sum = {{2{sample.sample_value[SAMPLE_W-1]}}, sample.sample_value}
			+ {{(SAMPLE_W + 2 - OFFSET_W){1'b0}}, offset_q};
		if (entry_sum[SAMPLE_W+1]) begin
			entry_clamped = '0;
		end else if (entry_sum[SAMPLE_W:AVG_W] != '0) begin
			entry_clamped = '1;
		end else begin
			entry_clamped = entry_sum[AVG_W-1:0];
		end
	end

	assign trial_in = {rem_q, dvd_q[PROD_W-1]};
	assign trial    = trial_in - {1'b0, dvs_q};
	assign trial_ge = (trial_in >= {1'b0, dvs_q});

	always_comb begin
		v        = dvd_q[AVG_W-1:0];
		th_full  = {full_q, 3'b000};
		th_upper = {upper_q, 3'b000};
		th_lower = {lower_q, 3'b000};
		th_empty = {empty_q, 3'b000};
		pick_num      = '0;
		pick_den      = '0;
		pick_base     = CHARGE_ZERO;
		pick_scale    = CHARGE_ZERO;
		pick_flat     = 1'b0;
		pick_flat_val = CHARGE_ZERO;
		if (v > th_upper) begin
			pick_num      = v - th_upper;
			pick_den      = th_full - th_upper;
			pick_base     = TOP_BASE;
			pick_scale    = TOP_SCALE;
			pick_flat     = (th_full <= th_upper);
			pick_flat_val = CHARGE_MAX;
		end else if (v < th_lower) begin
			pick_num   = v - th_empty;
			pick_den   = th_lower - th_empty;
			pick_base  = LOW_BASE;
			pick_scale = LOW_SCALE;
			if (th_lower <= th_empty) begin
				pick_flat     = 1'b1;
				pick_flat_val = MID_BASE;
			end else if (v <= th_empty) begin
				pick_flat     = 1'b1;
				pick_flat_val = CHARGE_ZERO;
			end
		end else begin
			pick_num      = v - th_lower;
			pick_den      = th_upper - th_lower;
			pick_base     = MID_BASE;
			pick_scale    = MID_SCALE;
			pick_flat     = (th_upper <= th_lower);
			pick_flat_val = TOP_BASE;
		end
	end

	always_comb begin
		charge_sum = {{(PROD_W + 1 - CHARGE_W){1'b0}}, base_q} + {1'b0, dvd_q};
		if (flat_q) begin
			charge = flat_val_q;
		end else if (charge_sum > (PROD_W + 1)'(CHARGE_MAX)) begin
			charge = CHARGE_MAX;
		end else begin
			charge = charge_sum[CHARGE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= FULL_RST;
			upper_q <= UPPER_RST;
			lower_q <= LOWER_RST;
			empty_q <= EMPTY_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_FULL:  full_q  <= cfg_data;
				REG_UPPER: upper_q <= cfg_data;
				REG_LOWER: lower_q <= cfg_data;
				REG_EMPTY: empty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			offset_q    <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_next;
			if (take_speed) begin
				offset_q <= load_offset(speed_sel);
			end
			case (cw.op)
				OP_WINDOW: begin
					sum_q  <= sum_q + SUM_W'(entry_q)
						- (win_full ? SUM_W'(win_q[slot_q]) : SUM_W'(0));
					fill_q <= win_full ? fill_q : fill_q + CNT_W'(1);
					slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
				end
				OP_AVG_LOAD: iter_q <= AVG_ITERS;
				OP_SEG_LOAD: iter_q <= SEG_ITERS;
				OP_DIV_STEP: iter_q <= iter_q - ITER_W'(1);
				default: ;
			endcase
			if (cw.op == OP_EMIT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_volt) begin
			entry_q <= entry_clamped;
		end
		case (cw.op)
			OP_WINDOW: win_q[slot_q] <= entry_q;
			OP_AVG_LOAD: begin
				dvd_q <= {sum_q, {ALIGN{1'b0}}};
				dvs_q <= {{(DVS_W - CNT_W){1'b0}}, fill_q};
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				dvd_q <= {dvd_q[PROD_W-2:0], trial_ge};
				rem_q <= trial_ge ? trial[DVS_W-1:0] : trial_in[DVS_W-1:0];
			end
			OP_SEG_PICK: begin
				avg_q      <= v;
				num_q      <= pick_num;
				den_q      <= pick_den;
				base_q     <= pick_base;
				scale_q    <= pick_scale;
				flat_q     <= pick_flat;
				flat_val_q <= pick_flat_val;
			end
			OP_SEG_LOAD: begin
				dvd_q <= {{(PROD_W - CHARGE_W){1'b0}}, scale_q}
					* {{(PROD_W - AVG_W){1'b0}}, num_q};
				dvs_q <= den_q;
				rem_q <= '0;
			end
			OP_EMIT: begin
				if (!out_busy) begin
					out_charge_q <= charge;
					out_avg_q    <= avg_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/bcv_checker.sv =====
`timescale 1ns / 1ps

module bcv_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [bcv_pkg::MODE_W-1:0]     in_mode,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [bcv_pkg::CHARGE_W-1:0]   out_charge,
	input logic [bcv_pkg::AVG_W-1:0]      out_avg
);
	import bcv_pkg::*;

	a_charge_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_charge <= CHARGE_MAX))
		else $error("charge above full scale");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_charge) && $stable(out_avg)))
		else $error("stalled result changed");

	a_volt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_mode == MODE_VOLT)) |=> !in_ready)
		else $error("voltage item did not occupy the sequencer");

	a_speed_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_mode == MODE_SPEED)) |=> in_ready)
		else $error("speed item blocked the next item");

endmodule

bind battery_charge_from_voltage bcv_checker u_bcv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample.valid),
	.in_ready   (sample.ready),
	.in_mode    (sample.mode),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_charge (result.charge_tenths),
	.out_avg    (result.avg_cell_eighth_mv)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import bcv_pkg::*;

	localparam int WIN_DEPTH    = WINDOW_DEPTH_DEF;
	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 145;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;

	typedef struct packed {
		logic [CHARGE_W-1:0] charge;
		logic [AVG_W-1:0]    avg;
	} gauge_out_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		int                value;
		bit                typed;
		gauge_out_t        want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [REG_W-1:0] cfg_data;

	bcv_sample_if sample_ch();
	bcv_result_if result_ch();

	battery_charge_from_voltage #(.WINDOW_DEPTH(WIN_DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	logic [REG_W-1:0] thr_full;
	logic [REG_W-1:0] thr_upper;
	logic [REG_W-1:0] thr_lower;
	logic [REG_W-1:0] thr_empty;
	logic [OFFSET_W-1:0] load_mv;
	logic [15:0] win_entries [WIN_DEPTH];
	int unsigned win_slot;
	int unsigned fill_cnt;
	logic [19:0] win_sum;

	gauge_out_t pending_readings[$];
	int mismatch_count;
	int stall_cycles;
	bit tx_quiet;
	bit rx_quiet;
	bit hold_req;

	stim_row_t directed_rows [22] = '{
		'{MODE_VOLT,  0,      1'b1, '{10'd0, 16'd0}},
		'{MODE_SPEED, 0,      1'b0, '{10'd0, 16'd0}},
		'{MODE_SPEED, 500,    1'b0, '{10'd0, 16'd0}},
		'{MODE_SPEED, 501,    1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  -65536, 1'b0, '{10'd0, 16'd0}},
		'{MODE_SPEED, -501,   1'b0, '{10'd0, 16'd0}},
		'{MODE_SPEED, 6000,   1'b0, '{10'd0, 16'd0}},
		'{MODE_SPEED, 6001,   1'b0, '{10'd0, 16'd0}},
		'{MODE_SPEED, 65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_SPEED, -65536, 1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_SPEED, 1,      1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b0, '{10'd0, 16'd0}},
		'{MODE_VOLT,  65535,  1'b1, '{10'd1000, 16'd65535}}
	};

	always #5 clk = ~clk;

	function automatic longint segment_value(input longint base, input longint scale,
			input longint num, input longint den);
		if (den <= 0)
			return base + scale;
		return base + (scale * num) / den;
	endfunction

	function automatic logic [CHARGE_W-1:0] charge_from_avg(input logic [AVG_W-1:0] avg);
		longint v;
		longint full;
		longint up;
		longint lo;
		longint em;
		longint c;
		v = avg;
		full = 8 * longint'(thr_full);
		up = 8 * longint'(thr_upper);
		lo = 8 * longint'(thr_lower);
		em = 8 * longint'(thr_empty);
		if (v > up) begin
			c = segment_value(850, 150, v - up, full - up);
		end else if (v < lo) begin
			if (lo - em <= 0)
				c = 100;
			else if (v <= em)
				c = 0;
			else
				c = segment_value(0, 100, v - em, lo - em);
		end else begin
			c = segment_value(100, 750, v - lo, up - lo);
		end
		if (c > 1000)
			c = 1000;
		if (c < 0)
			c = 0;
		return c[CHARGE_W-1:0];
	endfunction

	function automatic void gauge_step(input logic [MODE_W-1:0] m,
			input logic signed [SAMPLE_W-1:0] raw, output bit has_out, output gauge_out_t out);
		int v;
		int mag;
		int idx;
		int entry;
		int unsigned avg;
		v = raw;
		has_out = 1'b0;
		out = '0;
		if (m == MODE_SPEED) begin
			mag = (v < 0) ? -v : v;
			idx = (mag == 0) ? 0 : (mag - 1) / 500;
			if (idx > 11)
				idx = 11;
			load_mv = OFFSET_W'((idx == 0) ? 0 : (idx == 1) ? 100 : (idx + 1) * 100);
			return;
		end
		entry = v + int'(load_mv);
		if (entry < 0)
			entry = 0;
		if (entry > 65535)
			entry = 65535;
		if (fill_cnt >= WIN_DEPTH)
			win_sum = win_sum - 20'(win_entries[win_slot]);
		else
			fill_cnt++;
		win_entries[win_slot] = entry[15:0];
		win_sum = win_sum + 20'(entry);
		win_slot = (win_slot + 1 >= WIN_DEPTH) ? 0 : win_slot + 1;
		avg = win_sum / fill_cnt;
		out.avg = avg[AVG_W-1:0];
		out.charge = charge_from_avg(avg[AVG_W-1:0]);
		has_out = 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic offer_sample(input logic [MODE_W-1:0] m, input int v, input bit typed,
			input gauge_out_t want);
		int gap;
		bit has_out;
		gauge_out_t got;
		gap = tx_quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.mode <= m;
		sample_ch.sample_value <= v[SAMPLE_W-1:0];
		do @(posedge clk); while (!sample_ch.ready);
		gauge_step(m, v[SAMPLE_W-1:0], has_out, got);
		if (has_out)
			pending_readings.insert(pending_readings.size(), typed ? want : got);
	endtask

	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_thresholds(input int full, input int upper, input int lower,
			input int empty);
		cfg_we <= 1'b1;
		cfg_idx <= REG_FULL;
		cfg_data <= full[REG_W-1:0];
		@(posedge clk);
		cfg_idx <= REG_UPPER;
		cfg_data <= upper[REG_W-1:0];
		@(posedge clk);
		cfg_idx <= REG_LOWER;
		cfg_data <= lower[REG_W-1:0];
		@(posedge clk);
		cfg_idx <= REG_EMPTY;
		cfg_data <= empty[REG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_full = full[REG_W-1:0];
		thr_upper = upper[REG_W-1:0];
		thr_lower = lower[REG_W-1:0];
		thr_empty = empty[REG_W-1:0];
	endtask

	initial begin
		int f;
		int u;
		int l;
		int e;
		int lo_mv;
		int hi_mv;
		int r;
		int v;
		int thr_set [4];
		logic [MODE_W-1:0] m;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_FULL;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.mode = MODE_SPEED;
		sample_ch.sample_value = '0;
		mismatch_count = 0;
		tx_quiet = 1'b0;
		hold_req = 1'b0;
		thr_full = FULL_RST;
		thr_upper = UPPER_RST;
		thr_lower = LOWER_RST;
		thr_empty = EMPTY_RST;
		load_mv = '0;
		win_slot = 0;
		fill_cnt = 0;
		win_sum = '0;
		foreach (win_entries[i])
			win_entries[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_sample(directed_rows[i].mode, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin f = 4200; u = 3930; l = 3650; e = 3600; end
				1: begin f = 5000; u = 5000; l = 3000; e = 3000; end
				2: begin f = 3000; u = 3000; l = 3000; e = 3000; end
				3: begin f = 3000; u = 3500; l = 4000; e = 5000; end
				4: begin f = 8191; u = 6000; l = 2000; e = 0; end
				8: begin
					f = $urandom_range(0, 8191);
					u = $urandom_range(0, 8191);
					l = $urandom_range(0, 8191);
					e = $urandom_range(0, 8191);
				end
				default: begin
					e = $urandom_range(3000, 3600);
					l = e + $urandom_range(0, 500);
					u = l + $urandom_range(0, 500);
					f = u + $urandom_range(0, 400);
				end
			endcase
			load_thresholds(f, u, l, e);
			thr_set = '{f, u, l, e};
			lo_mv = f;
			hi_mv = f;
			foreach (thr_set[k]) begin
				if (thr_set[k] < lo_mv)
					lo_mv = thr_set[k];
				if (thr_set[k] > hi_mv)
					hi_mv = thr_set[k];
			end
			lo_mv = 8 * lo_mv - 800;
			hi_mv = 8 * hi_mv + 800;
			if (lo_mv < -65536)
				lo_mv = -65536;
			if (hi_mv > 65535)
				hi_mv = 65535;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 59) == 0)
					tx_quiet = !tx_quiet;
				if (p == 1 && n == 40)
					hold_req = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 30) begin
					m = MODE_SPEED;
					r = $urandom_range(0, 9);
					if (r == 0)
						v = int'($urandom_range(0, 131071)) - 65536;
					else if (r < 5)
						v = 500 * $urandom_range(0, 13) + $urandom_range(0, 2) - 1;
					else
						v = $urandom_range(0, 7000);
					if ($urandom_range(0, 1) == 1 && v > -65536)
						v = -v;
				end else begin
					m = MODE_VOLT;
					r = $urandom_range(0, 19);
					if (r < 2)
						v = int'($urandom_range(0, 131071)) - 65536;
					else if (r == 2)
						v = 65535;
					else if (r == 3)
						v = -65536;
					else
						v = lo_mv + int'($urandom_range(0, hi_mv - lo_mv));
				end
				offer_sample(m, v, 1'b0, '0);
			end
		end

		settle();
		if (pending_readings.size() != 0)
			report_mismatch("readings left over", 0, pending_readings.size());
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		int gap;
		gauge_out_t want;
		result_ch.ready = 1'b0;
		rx_quiet = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				rx_quiet = !rx_quiet;
			gap = rx_quiet ? 0 : $urandom_range(0, 9);
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			if (pending_readings.size() == 0) begin
				report_mismatch("unexpected reading, charge", result_ch.charge_tenths, -1);
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.charge_tenths !== want.charge)
					report_mismatch("charge_tenths", result_ch.charge_tenths, want.charge);
				if (result_ch.avg_cell_eighth_mv !== want.avg)
					report_mismatch("avg_cell_eighth_mv", result_ch.avg_cell_eighth_mv,
						want.avg);
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| cfg_we || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
